// ===== rtl/page_frame_bitmap_allocator_unit_macros.svh =====
// assertion macros shared by the checker file
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfba_pkg.sv =====
package pfba_pkg;

  // map geometry
  localparam int TRACKED_PAGES = 16384;
  localparam int MAP_WORDS     = TRACKED_PAGES / 32;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int PAGE_W        = WORD_AW + 5;
  localparam int COUNT_W       = 15;
  localparam int PAGE_SHIFT    = 12;
  localparam int CLEAR_CYCLES  = MAP_WORDS;

  // request codes
  localparam logic [2:0] REQ_ALLOC       = 3'd0;
  localparam logic [2:0] REQ_ALLOC_BELOW = 3'd1;
  localparam logic [2:0] REQ_FREE        = 3'd2;
  localparam logic [2:0] REQ_MARK_USED   = 3'd3;
  localparam logic [2:0] REQ_MARK_FREE   = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_SET,
    OP_CLR
  } op_mode_t;

endpackage

// ===== rtl/pfba_in_if.sv =====
interface pfba_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] address;
  logic [31:0] end_address;
  logic [31:0] limit_address;

  modport source (output valid, req_type, address, end_address, limit_address,
                  input ready);
  modport sink   (input valid, req_type, address, end_address, limit_address,
                  output ready);
endinterface

// ===== rtl/pfba_out_if.sv =====
interface pfba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_address;
  logic        success;

  modport source (output valid, page_address, success, input ready);
  modport sink   (input valid, page_address, success, output ready);
endinterface

// ===== rtl/page_frame_bitmap_allocator_unit.sv =====
// Bitmap page frame allocator: one used bit per 4 KiB page, 32 pages per word of a
// one-read one-write map memory with registered reads. After reset the block fills all
// 512 map words with ones (every page used) and takes no request until it is done;
// page_count writes are taken throughout. Each request walks the map words it touches,
// one word per cycle in read-modify-write order, then a response state loads its result
// into the output register once that register is free or being drained, and the block
// returns to idle to take the next request. A free walks one word, a mark the words it
// spans, and an allocation the words up to the first word holding a free page (at most
// all 512 words of the full map of 16384 pages). A request whose range is empty skips
// the walk. One request is in service at a time; a finished result waits in the output
// register while the next request is accepted.
module page_frame_bitmap_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  pfba_in_if.sink                           in_ch,
  pfba_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [pfba_pkg::COUNT_W-1:0]      cfg_wdata
);

  localparam int AW = pfba_pkg::WORD_AW;
  localparam int PW = pfba_pkg::PAGE_W;
  localparam int CW = pfba_pkg::COUNT_W;

  pfba_pkg::state_t   state_r, state_nxt;
  pfba_pkg::op_mode_t mode_r, mode_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] page_count_r;
  logic [PW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] cur_w_r, cur_w_nxt;
  logic [AW-1:0] last_w_r, last_w_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  logic          out_ok_r, out_ok_nxt;

  // map memory
  logic [31:0]   map_mem [pfba_pkg::MAP_WORDS];
  logic [31:0]   rdata_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_wdata;

  // request decode
  logic [CW-1:0] bound;
  logic [31:0]   addr_up, end_up;
  logic [19:0]   first_pg;
  logic [20:0]   stop_raw;
  logic [20:0]   stop_clip;
  logic [CW-1:0] stop_last;
  logic          range_empty;
  pfba_pkg::op_mode_t dec_mode;

  // word walk
  logic [31:0]   word_mask;
  logic [31:0]   cand;
  logic [31:0]   low_bit;
  logic [4:0]    low_idx;
  logic [PW-1:0] bit_pg;

  assign in_ch.ready         = (state_r == pfba_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.page_address = out_addr_r;
  assign out_ch.success      = out_ok_r;

  // effective page bound
  always_comb begin
    if (page_count_r > CW'(pfba_pkg::TRACKED_PAGES)) begin
      bound = CW'(pfba_pkg::TRACKED_PAGES);
    end else begin
      bound = page_count_r;
    end
  end

  // page range of the incoming request
  always_comb begin
    addr_up  = in_ch.address + 32'd4095;
    end_up   = in_ch.end_address + 32'd4095;
    first_pg = 20'd0;
    stop_raw = 21'd0;
    dec_mode = pfba_pkg::OP_SET;
    case (in_ch.req_type)
      pfba_pkg::REQ_ALLOC: begin
        first_pg = 20'd1;
        stop_raw = 21'(bound);
        dec_mode = pfba_pkg::OP_FIND;
      end
      pfba_pkg::REQ_ALLOC_BELOW: begin
        first_pg = 20'd1;
        stop_raw = {1'b0, in_ch.limit_address[31:12]};
        dec_mode = pfba_pkg::OP_FIND;
      end
      pfba_pkg::REQ_FREE: begin
        first_pg = in_ch.address[31:12];
        stop_raw = {1'b0, in_ch.address[31:12]} + 21'd1;
        dec_mode = pfba_pkg::OP_CLR;
      end
      pfba_pkg::REQ_MARK_USED: begin
        first_pg = in_ch.address[31:12];
        stop_raw = {1'b0, end_up[31:12]};
        dec_mode = pfba_pkg::OP_SET;
      end
      pfba_pkg::REQ_MARK_FREE: begin
        first_pg = addr_up[31:12];
        stop_raw = {1'b0, in_ch.end_address[31:12]};
        dec_mode = pfba_pkg::OP_CLR;
      end
      default: begin
        first_pg = 20'd0;
        stop_raw = 21'd0;
        dec_mode = pfba_pkg::OP_SET;
      end
    endcase
    if (stop_raw > 21'(bound)) begin
      stop_clip = 21'(bound);
    end else begin
      stop_clip = stop_raw;
    end
    range_empty = ({1'b0, first_pg} >= stop_clip);
    stop_last   = stop_clip[CW-1:0] - CW'(1);
  end

  // bits of the current word inside [lo, hi)
  always_comb begin
    word_mask = '0;
    bit_pg    = '0;
    for (int i = 0; i < 32; i++) begin
      bit_pg       = {cur_w_r, 5'(i)};
      word_mask[i] = (bit_pg >= lo_r) && (CW'(bit_pg) < hi_r);
    end
  end

  // lowest free page in the current word
  always_comb begin
    cand    = ~rdata_r & word_mask;
    low_bit = cand & (~cand + 32'd1);
    low_idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | 5'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    clr_nxt       = clr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_w_nxt     = cur_w_r;
    last_w_nxt    = last_w_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;
    mem_re        = 1'b0;
    mem_raddr     = cur_w_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_w_r;
    mem_wdata     = rdata_r;

    // output register drains
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pfba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '1;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(pfba_pkg::CLEAR_CYCLES - 1)) begin
          state_nxt = pfba_pkg::ST_IDLE;
        end
      end
      pfba_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt     = dec_mode;
          res_addr_nxt = '0;
          res_ok_nxt   = (dec_mode != pfba_pkg::OP_FIND);
          if (range_empty) begin
            state_nxt = pfba_pkg::ST_RESP;
          end else begin
            lo_nxt     = first_pg[PW-1:0];
            hi_nxt     = stop_clip[CW-1:0];
            cur_w_nxt  = first_pg[PW-1:5];
            last_w_nxt = stop_last[PW-1:5];
            mem_re     = 1'b1;
            mem_raddr  = first_pg[PW-1:5];
            state_nxt  = pfba_pkg::ST_SCAN;
          end
        end
      end
      pfba_pkg::ST_SCAN: begin
        case (mode_r)
          pfba_pkg::OP_FIND: begin
            if (|cand) begin
              mem_we       = 1'b1;
              mem_wdata    = rdata_r | low_bit;
              res_addr_nxt = 32'({cur_w_r, low_idx, 12'd0});
              res_ok_nxt   = 1'b1;
              state_nxt    = pfba_pkg::ST_RESP;
            end else if (cur_w_r == last_w_r) begin
              res_addr_nxt = '0;
              res_ok_nxt   = 1'b0;
              state_nxt    = pfba_pkg::ST_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cur_w_r + AW'(1);
              cur_w_nxt = cur_w_r + AW'(1);
            end
          end
          pfba_pkg::OP_SET, pfba_pkg::OP_CLR: begin
            mem_we = 1'b1;
            if (mode_r == pfba_pkg::OP_SET) begin
              mem_wdata = rdata_r | word_mask;
            end else begin
              mem_wdata = rdata_r & ~word_mask;
            end
            if (cur_w_r == last_w_r) begin
              state_nxt = pfba_pkg::ST_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cur_w_r + AW'(1);
              cur_w_nxt = cur_w_r + AW'(1);
            end
          end
          default: begin
            state_nxt = pfba_pkg::ST_RESP;
          end
        endcase
      end
      pfba_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_ok_nxt    = res_ok_r;
          state_nxt     = pfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfba_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfba_pkg::ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      page_count_r <= CW'(pfba_pkg::TRACKED_PAGES);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        page_count_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_w_r    <= cur_w_nxt;
    last_w_r   <= last_w_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  // map memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= map_mem[mem_raddr];
    end
  end

endmodule

// ===== rtl/pfba_checker.sv =====
`include "page_frame_bitmap_allocator_unit_macros.svh"

module pfba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_page_address,
  input logic        out_success
);

  // a stalled result word stays offered
  `PFBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // a stalled result word keeps its payload
  `PFBA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_page_address) && $stable(out_success), "result payload changed while stalled")

  // one request in service at a time
  `PFBA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input still ready after accepting a word")

  // a result appears only after a service cycle
  `PFBA_ASSERT_IMPL(a_result_after_service, $rose(out_valid), !$past(in_ready), "result raised straight from idle")

endmodule

bind page_frame_bitmap_allocator_unit pfba_checker u_pfba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_page_address (out_ch.page_address),
  .out_success      (out_ch.success)
);
